@@ sv/ising_heat_bath_site_update_defines.svh @@
// ----------------------------------------------------------------------------
// Ising heat bath site update - assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ISING_HEAT_BATH_SITE_UPDATE_DEFINES_SVH
`define ISING_HEAT_BATH_SITE_UPDATE_DEFINES_SVH
`ifndef SYNTH
`define IHB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IHB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IHB_ASSERT(lbl, clk, rst, prop, msg)
`define IHB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/ihb_pkg.sv @@
// ----------------------------------------------------------------------------
// Ising heat bath package
// Shared types, neighborhood taps, register indexes and the sigmoid table.
// ----------------------------------------------------------------------------
package ihb_pkg;
   localparam int ROWS_DEF  = 64;
   localparam int COLS_DEF  = 64;
   localparam int RC_W      = 9;
   localparam int IN_RC_W   = 6;
   localparam int RND_W     = 16;
   localparam int COEF_W    = 16;
   localparam int NCOEF     = 6;
   localparam int NGRP      = 5;
   localparam int NTAP      = 25;
   localparam int TAP_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam int SIG_N     = 256;
   localparam int SIG_W     = $clog2(SIG_N);
   localparam real SIG_HALF_STEP = 4.0 / SIG_N;

   localparam logic OP_SET  = 1'b0;
   localparam logic OP_FLIP = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_GAIN   = 3'd0,
      CSR_NEAR_AXIS    = 3'd1,
      CSR_NEAR_DIAG    = 3'd2,
      CSR_FAR_AXIS     = 3'd3,
      CSR_KNIGHT       = 3'd4,
      CSR_FAR_DIAG     = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic              op;
      logic [RC_W-1:0]   row;
      logic [RC_W-1:0]   col;
      logic              spin;
      logic [RND_W-1:0]  rnd;
   } item_type;

   typedef struct packed {
      logic clearing;
   } bstat_type;

   // tap 0 is the site itself
   localparam logic signed [2:0] TAP_DR [NTAP] = '{
      3'sd0,
      3'sd1, -3'sd1, 3'sd0, 3'sd0,
      3'sd1, 3'sd1, -3'sd1, -3'sd1,
      3'sd2, -3'sd2, 3'sd0, 3'sd0,
      3'sd2, 3'sd2, -3'sd2, -3'sd2, 3'sd1, 3'sd1, -3'sd1, -3'sd1,
      3'sd2, 3'sd2, -3'sd2, -3'sd2};
   localparam logic signed [2:0] TAP_DC [NTAP] = '{
      3'sd0,
      3'sd0, 3'sd0, 3'sd1, -3'sd1,
      3'sd1, -3'sd1, 3'sd1, -3'sd1,
      3'sd0, 3'sd0, 3'sd2, -3'sd2,
      3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd2, -3'sd2, 3'sd2, -3'sd2,
      3'sd2, -3'sd2, 3'sd2, -3'sd2};
   localparam logic [2:0] TAP_GRP [NTAP] = '{
      3'd0,
      3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4};

   typedef logic [RND_W-1:0] sig_tbl_type [SIG_N];

   // sigmoid(2x) = (1 + tanh(x)) / 2, x is half the bin centre
   function automatic sig_tbl_type build_sig_tbl();
      sig_tbl_type t;
      real         x;
      real         v;
      int          q;
      int          k;
      for (k = 0; k < SIG_N; k++) begin
         x = real'(2 * k + 1 - SIG_N) * SIG_HALF_STEP;
         v = 32768.0 + 32768.0 * $tanh(x);
         q = $rtoi($floor(v));
         if (q > 65535) q = 65535;
         t[k] = q[RND_W-1:0];
      end
      return t;
   endfunction

   localparam sig_tbl_type SIG_TBL = build_sig_tbl();
endpackage

@@ sv/ihb_front.sv @@
// ----------------------------------------------------------------------------
// Ising heat bath front
// Takes request words and folds the site address into the lattice range.
// ----------------------------------------------------------------------------
module ihb_front import ihb_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_op,
   input  logic [IN_RC_W-1:0]   req_site_row,
   input  logic [IN_RC_W-1:0]   req_site_col,
   input  logic                 req_spin_value,
   input  logic [RND_W-1:0]     req_random_value,
   input  bstat_type            bstat,
   input  logic                 q_full,
   output logic                 q_push,
   output item_type             q_item
);
   localparam logic [RC_W-1:0] ROWS_C = RC_W'(ROWS);
   localparam logic [RC_W-1:0] COLS_C = RC_W'(COLS);

   logic     busy_ff, busy_in;
   item_type item_ff, item_in;
   logic     row_ok, col_ok;

   assign row_ok   = item_ff.row < ROWS_C;
   assign col_ok   = item_ff.col < COLS_C;
   assign req_full = busy_ff | bstat.clearing;
   assign q_push   = busy_ff & row_ok & col_ok & ~q_full;
   assign q_item   = item_ff;

   always_comb begin
      busy_in = busy_ff;
      item_in = item_ff;
      if (!busy_ff) begin
         if (req_push && !req_full) begin
            busy_in      = 1'b1;
            item_in.op   = req_op;
            item_in.row  = RC_W'(req_site_row);
            item_in.col  = RC_W'(req_site_col);
            item_in.spin = req_spin_value;
            item_in.rnd  = req_random_value;
         end
      end else begin
         // fold one step per cycle
         if (!row_ok) item_in.row = item_ff.row - ROWS_C;
         if (!col_ok) item_in.col = item_ff.col - COLS_C;
         if (q_push)  busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      item_ff <= item_in;
   end
endmodule

@@ sv/ihb_queue.sv @@
// ----------------------------------------------------------------------------
// Ising heat bath queue
// Two-entry queue of folded requests between front and back.
// ----------------------------------------------------------------------------
module ihb_queue import ihb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);
   item_type   ent_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_item = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (!push && pop) cnt_ff <= cnt_ff - 2'd1;
      end
      if (push) ent_ff[wp_ff] <= push_item;
   end
endmodule

@@ sv/ihb_back.sv @@
// ----------------------------------------------------------------------------
// Ising heat bath back
// Holds the lattice and running sums, gathers the neighborhood, forms dE,
// draws flips against the sigmoid table and writes the spin back.
// ----------------------------------------------------------------------------
`include "ising_heat_bath_site_update_defines.svh"
module ihb_back import ihb_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_wdata,
   input  logic                  q_empty,
   input  item_type              q_item,
   output logic                  q_pop,
   output bstat_type             bstat,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_spin_after,
   output logic                  rsp_flipped,
   output logic signed [13:0]    rsp_total_spin,
   output logic signed [14:0]    rsp_near_axis_sum,
   output logic signed [14:0]    rsp_near_diag_sum,
   output logic signed [14:0]    rsp_far_axis_sum,
   output logic signed [15:0]    rsp_knight_sum,
   output logic signed [14:0]    rsp_far_diag_sum
);
   localparam int NSITE = ROWS * COLS;
   localparam int AW    = $clog2(NSITE);
   localparam logic signed [RC_W+1:0] ROWS_S = (RC_W+2)'(ROWS);
   localparam logic signed [RC_W+1:0] COLS_S = (RC_W+2)'(COLS);
   localparam logic signed [13:0] X0_RST   = 14'(NSITE);
   localparam logic signed [15:0] PAIR_RST = 16'(2 * NSITE);
   localparam logic signed [15:0] KN_RST   = 16'(4 * NSITE);
   localparam logic [AW-1:0]      CLR_LAST = AW'(NSITE - 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_MAC, S_DECIDE, S_WRITE
   } st_type;

   st_type                    st_ff;
   logic [AW-1:0]             clr_ff;
   item_type                  item_ff;
   logic [TAP_W-1:0]          tap_ff, rdtap_ff;
   logic                      rdv_ff;
   logic                      rd_ff;
   logic                      neg_ff;
   logic signed [4:0]         nsum_ff [NGRP];
   logic [2:0]                mac_ff;
   logic signed [21:0]        prod_ff;
   logic signed [23:0]        acc_ff;
   logic                      flip_ff;
   logic signed [COEF_W-1:0]  coef_ff [NCOEF];
   logic signed [13:0]        x0_ff;
   logic signed [15:0]        pair_ff [NGRP];
   logic                      rsp_valid_ff;
   logic                      spin_ff, flipped_ff;
   logic                      mem [NSITE];

   logic [TAP_W-1:0]          tap_sel;
   logic signed [RC_W+1:0]    nr_s, nc_s;
   logic [AW-1:0]             rd_addr, ctr_addr;
   logic                      mem_we, mem_wd;
   logic [AW-1:0]             mem_wa;
   logic signed [5:0]         base, dbl, mult;
   logic signed [15:0]        clamp;
   logic [SIG_W-1:0]          sig_idx;
   logic                      flip_dec;

   assign tap_sel = (tap_ff < TAP_W'(NTAP)) ? tap_ff : '0;

   always_comb begin
      nr_s = $signed({2'b00, item_ff.row}) + (RC_W+2)'(TAP_DR[tap_sel]);
      nc_s = $signed({2'b00, item_ff.col}) + (RC_W+2)'(TAP_DC[tap_sel]);
      if (nr_s < 0)            nr_s = nr_s + ROWS_S;
      else if (nr_s >= ROWS_S) nr_s = nr_s - ROWS_S;
      if (nc_s < 0)            nc_s = nc_s + COLS_S;
      else if (nc_s >= COLS_S) nc_s = nc_s - COLS_S;
      rd_addr  = AW'(int'(nr_s) * COLS + int'(nc_s));
      ctr_addr = AW'(int'(item_ff.row) * COLS + int'(item_ff.col));
   end

   always_comb begin
      base = (mac_ff == 3'd0) ? 6'sd1 : 6'(nsum_ff[mac_ff - 3'd1]);
      dbl  = {base[4:0], 1'b0};
      mult = neg_ff ? dbl : -dbl;
   end

   always_comb begin
      if (acc_ff < -24'sd32768)     clamp = 16'sh8000;
      else if (acc_ff > 24'sd32767) clamp = 16'sh7fff;
      else                          clamp = acc_ff[15:0];
      sig_idx = {~clamp[15], clamp[14:16-SIG_W]};
      if (item_ff.op == OP_FLIP) flip_dec = item_ff.rnd > SIG_TBL[sig_idx];
      else                       flip_dec = item_ff.spin == neg_ff;
   end

   assign q_pop     = (st_ff == S_IDLE) & ~q_empty;
   assign mem_we    = (st_ff == S_CLEAR) | ((st_ff == S_WRITE) & ~rsp_valid_ff & flip_ff);
   assign mem_wa    = (st_ff == S_CLEAR) ? clr_ff : ctr_addr;
   assign mem_wd    = (st_ff == S_CLEAR) ? 1'b0 : ~neg_ff;
   assign bstat.clearing = st_ff == S_CLEAR;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         x0_ff        <= X0_RST;
         for (int k = 0; k < NGRP; k++) pair_ff[k] <= (k == 3) ? KN_RST : PAIR_RST;
         for (int k = 0; k < NCOEF; k++) coef_ff[k] <= '0;
      end else begin
         if (csr_we && csr_index <= CSR_FAR_DIAG) coef_ff[csr_index] <= csr_wdata;
         if (rsp_pop && rsp_valid_ff) rsp_valid_ff <= 1'b0;
         unique case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == CLR_LAST) st_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (q_pop) begin
                  item_ff <= q_item;
                  tap_ff  <= '0;
                  for (int k = 0; k < NGRP; k++) nsum_ff[k] <= '0;
                  st_ff   <= S_READ;
               end
            end
            S_READ: begin
               rdv_ff   <= tap_ff < TAP_W'(NTAP);
               rdtap_ff <= tap_ff;
               if (rdv_ff) begin
                  if (rdtap_ff == '0) neg_ff <= rd_ff;
                  else nsum_ff[TAP_GRP[rdtap_ff]] <= nsum_ff[TAP_GRP[rdtap_ff]]
                                                     + (rd_ff ? -5'sd1 : 5'sd1);
               end
               if (tap_ff == TAP_W'(NTAP)) begin
                  mac_ff <= '0;
                  acc_ff <= '0;
                  st_ff  <= S_MAC;
               end else begin
                  tap_ff <= tap_ff + TAP_W'(1);
               end
            end
            S_MAC: begin
               rdv_ff <= 1'b0;
               if (mac_ff != 3'd0) acc_ff <= acc_ff + 24'(prod_ff);
               if (mac_ff < 3'(NCOEF)) prod_ff <= 22'(coef_ff[mac_ff]) * 22'(mult);
               mac_ff <= mac_ff + 3'd1;
               if (mac_ff == 3'(NCOEF)) st_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               flip_ff <= flip_dec;
               st_ff   <= S_WRITE;
            end
            S_WRITE: begin
               if (!rsp_valid_ff) begin
                  if (flip_ff) begin
                     x0_ff <= x0_ff + (neg_ff ? 14'sd2 : -14'sd2);
                     for (int k = 0; k < NGRP; k++)
                        pair_ff[k] <= pair_ff[k] + (neg_ff ? 16'(nsum_ff[k]) <<< 1
                                                           : -(16'(nsum_ff[k]) <<< 1));
                  end
                  spin_ff      <= ~(neg_ff ^ flip_ff);
                  flipped_ff   <= flip_ff;
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_empty         = ~rsp_valid_ff;
   assign rsp_spin_after    = spin_ff;
   assign rsp_flipped       = flipped_ff;
   assign rsp_total_spin    = x0_ff;
   assign rsp_near_axis_sum = pair_ff[0][14:0];
   assign rsp_near_diag_sum = pair_ff[1][14:0];
   assign rsp_far_axis_sum  = pair_ff[2][14:0];
   assign rsp_knight_sum    = pair_ff[3];
   assign rsp_far_diag_sum  = pair_ff[4][14:0];

   `IHB_ASSERT(a_clear_quiet, clock, reset, (st_ff == S_CLEAR) |-> !rsp_valid_ff, "word during clear")
   `IHB_ASSERT(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff) |-> ($past(st_ff) == S_WRITE), "word not from write")
   `IHB_ASSERT(a_total_parity, clock, reset, x0_ff[0] == X0_RST[0], "total spin parity lost")
endmodule

@@ sv/ising_heat_bath_site_update.sv @@
// ----------------------------------------------------------------------------
// Ising heat bath site update - top level
// Toroidal spin lattice with running pair sums and heat bath flips.
// ----------------------------------------------------------------------------
// Request side is a queue input: drive the word and raise req_push; it is
// taken when req_full is low. op 0 writes spin_value at the site, op 1
// proposes a flip drawn against random_value.
// Result side is a queue output: while rsp_empty is low the word shows the
// spin after the step, the flip flag and all six running sums; rsp_pop
// takes it.
// csr_we writes csr_wdata into register csr_index (0 field gain, 1 to 5
// the couplings) in the same cycle; write only while idle.
// The back reads the 25-site neighborhood one lattice bit per cycle, then
// runs six multiply steps on a single multiplier, a decide step (a table
// draw for op 1) and a write. One request is in work at a time, so the back
// takes no new word until the last result is written; two more wait in the
// queue. After reset the lattice is cleared to all plus one with req_full
// held high. A stalled result holds the back at its write step; the front
// and queue still take up to three further requests.
// ----------------------------------------------------------------------------
module ising_heat_bath_site_update import ihb_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_op,
   input  logic [IN_RC_W-1:0]    req_site_row,
   input  logic [IN_RC_W-1:0]    req_site_col,
   input  logic                  req_spin_value,
   input  logic [RND_W-1:0]      req_random_value,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_spin_after,
   output logic                  rsp_flipped,
   output logic signed [13:0]    rsp_total_spin,
   output logic signed [14:0]    rsp_near_axis_sum,
   output logic signed [14:0]    rsp_near_diag_sum,
   output logic signed [14:0]    rsp_far_axis_sum,
   output logic signed [15:0]    rsp_knight_sum,
   output logic signed [14:0]    rsp_far_diag_sum,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_wdata
);
   bstat_type bstat;
   logic      q_push, q_full, q_pop, q_empty;
   item_type  q_in, q_out;

   ihb_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_op, .req_site_row,
      .req_site_col, .req_spin_value, .req_random_value, .bstat,
      .q_full, .q_push, .q_item(q_in)
   );

   ihb_queue u_queue (
      .clock, .reset, .push(q_push), .push_item(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_item(q_out)
   );

   ihb_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .q_empty,
      .q_item(q_out), .q_pop, .bstat, .rsp_empty, .rsp_pop, .rsp_spin_after,
      .rsp_flipped, .rsp_total_spin, .rsp_near_axis_sum, .rsp_near_diag_sum,
      .rsp_far_axis_sum, .rsp_knight_sum, .rsp_far_diag_sum
   );
endmodule

@@ tb/ihb_lattice_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising heat bath lattice checker
// Watches the request, result and register ports, keeps its own copy of the
// lattice, sums and couplings, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module ihb_lattice_checker import ihb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic                 req_op,
   input  logic [IN_RC_W-1:0]   req_site_row,
   input  logic [IN_RC_W-1:0]   req_site_col,
   input  logic                 req_spin_value,
   input  logic [RND_W-1:0]     req_random_value,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic                 rsp_spin_after,
   input  logic                 rsp_flipped,
   input  logic [13:0]          rsp_total_spin,
   input  logic [14:0]          rsp_near_axis_sum,
   input  logic [14:0]          rsp_near_diag_sum,
   input  logic [14:0]          rsp_far_axis_sum,
   input  logic [15:0]          rsp_knight_sum,
   input  logic [14:0]          rsp_far_diag_sum,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   output int                   mismatch_count,
   output int                   pending_words
);
   localparam int LAT_ROWS = 64;
   localparam int LAT_COLS = 64;
   localparam int NNB = 24;
   localparam int NB_DR [NNB] = '{1, -1, 0, 0, 1, 1, -1, -1, 2, -2, 0, 0,
      2, 2, -2, -2, 1, 1, -1, -1, 2, 2, -2, -2};
   localparam int NB_DC [NNB] = '{0, 0, 1, -1, 1, -1, 1, -1, 0, 0, 2, -2,
      1, -1, 1, -1, 2, -2, 2, -2, 2, -2, 2, -2};
   localparam int NB_GRP [NNB] = '{0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
      3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 4};

   typedef struct packed {
      logic        spin_after;
      logic        flipped;
      logic [13:0] total_spin;
      logic [14:0] near_axis;
      logic [14:0] near_diag;
      logic [14:0] far_axis;
      logic [15:0] knight;
      logic [14:0] far_diag;
   } site_result_type;

   bit               spin_down [LAT_ROWS][LAT_COLS];
   int               spin_sum;
   int               pair_sums [NGRP];
   int               field_gain;
   int               couplings [NGRP];
   logic [15:0]      flip_threshold [SIG_N];
   site_result_type  expected_words [$];

   function automatic longint unsigned exp_q32(longint unsigned a, longint unsigned b);
      longint unsigned term;
      longint unsigned acc;
      longint unsigned k;
      term = 64'd1 << 32;
      acc = term;
      for (k = 1; k < 200 && term != 0; k++) begin
         term = (term * a) / (b * k);
         acc += term;
      end
      return acc;
   endfunction

   task automatic build_thresholds();
      int              m;
      longint unsigned e;
      longint unsigned v;
      for (int k = 0; k < SIG_N; k++) begin
         m = 2 * k + 1 - SIG_N;
         e = exp_q32(8 * (m < 0 ? -m : m), SIG_N);
         if (m >= 0) v = (e << 16) / (e + (64'd1 << 32));
         else v = (64'd1 << 48) / (e + (64'd1 << 32));
         if (v > 65535) v = 65535;
         flip_threshold[k] = v[15:0];
      end
   endtask

   task automatic clear_lattice();
      foreach (spin_down[r, c]) spin_down[r][c] = 0;
      spin_sum = LAT_ROWS * LAT_COLS;
      foreach (pair_sums[g]) pair_sums[g] = 2 * LAT_ROWS * LAT_COLS;
      pair_sums[3] = 4 * LAT_ROWS * LAT_COLS;
      field_gain = 0;
      foreach (couplings[g]) couplings[g] = 0;
      expected_words.delete();
   endtask

   task automatic update_site(logic op, int r, int c, logic want, logic [15:0] rnd);
      int               s;
      int               nsum [NGRP];
      int               dq [NGRP];
      int               de;
      int               nr;
      int               nc;
      bit               flip;
      site_result_type  w;
      s = spin_down[r][c] ? -1 : 1;
      foreach (nsum[g]) nsum[g] = 0;
      for (int i = 0; i < NNB; i++) begin
         nr = (r + NB_DR[i] + LAT_ROWS) % LAT_ROWS;
         nc = (c + NB_DC[i] + LAT_COLS) % LAT_COLS;
         nsum[NB_GRP[i]] += spin_down[nr][nc] ? -1 : 1;
      end
      foreach (dq[g]) dq[g] = -2 * s * nsum[g];
      if (op == OP_SET) begin
         flip = ((want ? 1 : -1) != s);
      end else begin
         de = field_gain * (-2 * s);
         foreach (dq[g]) de += couplings[g] * dq[g];
         if (de < -32768) de = -32768;
         if (de > 32767) de = 32767;
         flip = rnd > flip_threshold[(de + 32768) >> 8];
      end
      if (flip) begin
         spin_sum += -2 * s;
         foreach (dq[g]) pair_sums[g] += dq[g];
         spin_down[r][c] = !spin_down[r][c];
         s = -s;
      end
      w.spin_after = (s > 0);
      w.flipped = flip;
      w.total_spin = spin_sum[13:0];
      w.near_axis = pair_sums[0][14:0];
      w.near_diag = pair_sums[1][14:0];
      w.far_axis = pair_sums[2][14:0];
      w.knight = pair_sums[3][15:0];
      w.far_diag = pair_sums[4][14:0];
      expected_words.push_back(w);
   endtask

   initial begin
      mismatch_count = 0;
      build_thresholds();
      clear_lattice();
   end

   assign pending_words = expected_words.size();

   always @(posedge clock) begin
      site_result_type got;
      site_result_type want;
      if (reset) begin
         clear_lattice();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FIELD_GAIN) field_gain = int'($signed(csr_wdata));
            else if (csr_index <= CSR_FAR_DIAG)
               couplings[csr_index - 1] = int'($signed(csr_wdata));
         end
         if (!rsp_empty && rsp_pop) begin
            got = '{rsp_spin_after, rsp_flipped, rsp_total_spin, rsp_near_axis_sum,
                    rsp_near_diag_sum, rsp_far_axis_sum, rsp_knight_sum,
                    rsp_far_diag_sum};
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word %p", got);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch at %0t: expected %p actual %p", $realtime, want, got);
               end
            end
         end
         if (req_push && !req_full)
            update_site(req_op, req_site_row, req_site_col, req_spin_value,
                        req_random_value);
      end
   end
endmodule

@@ tb/tb_ising_heat_bath_site_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising heat bath site update testbench
// Drives directed and random set and flip words through several coupling
// settings with random gaps and result stalls; the checker predicts results.
// ----------------------------------------------------------------------------
module tb_ising_heat_bath_site_update;
   import ihb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_push = 0;
   logic                 req_full;
   logic                 req_op = 0;
   logic [IN_RC_W-1:0]   req_site_row = 0;
   logic [IN_RC_W-1:0]   req_site_col = 0;
   logic                 req_spin_value = 0;
   logic [RND_W-1:0]     req_random_value = 0;
   logic                 rsp_empty;
   logic                 rsp_pop = 0;
   logic                 rsp_spin_after;
   logic                 rsp_flipped;
   logic signed [13:0]   rsp_total_spin;
   logic signed [14:0]   rsp_near_axis_sum;
   logic signed [14:0]   rsp_near_diag_sum;
   logic signed [14:0]   rsp_far_axis_sum;
   logic signed [15:0]   rsp_knight_sum;
   logic signed [14:0]   rsp_far_diag_sum;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FIELD_GAIN;
   logic [COEF_W-1:0]    csr_wdata = 0;
   int                   mismatch_count;
   int                   pending_words;
   int                   cycle_count = 0;
   bit                   no_gaps = 0;
   int                   pop_hold = 0;

   always #6 clock = ~clock;

   ising_heat_bath_site_update dut (.*);

   ihb_lattice_checker checker_i (.*);

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (no_gaps || p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop = 0;
         pop_hold--;
      end else begin
         rsp_pop = 1;
         pop_hold = pick_gap();
      end
   end

   task automatic send_word(logic op, logic [5:0] r, logic [5:0] c, logic sv,
                            logic [15:0] rnd);
      int gap;
      req_op = op;
      req_site_row = r;
      req_site_col = c;
      req_spin_value = sv;
      req_random_value = rnd;
      req_push = 1;
      while (req_full) @(negedge clock);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_push = 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_push = 0;
      while (pending_words != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] data);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic set_couplings(logic [15:0] g, logic [15:0] a, logic [15:0] b,
                                logic [15:0] c, logic [15:0] d, logic [15:0] e);
      drain();
      write_reg(CSR_FIELD_GAIN, g);
      write_reg(CSR_NEAR_AXIS, a);
      write_reg(CSR_NEAR_DIAG, b);
      write_reg(CSR_FAR_AXIS, c);
      write_reg(CSR_KNIGHT, d);
      write_reg(CSR_FAR_DIAG, e);
   endtask

   function automatic logic [15:0] rand_coef(int mode);
      if (mode == 0) return 16'($signed($urandom_range(0, 2048)) - 1024);
      return 16'($urandom);
   endfunction

   task automatic random_run(int count, int mode);
      logic [5:0] r;
      logic [5:0] c;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 1)) begin
            r = 6'(60 + $urandom_range(0, 7));
            c = 6'(60 + $urandom_range(0, 7));
         end else begin
            r = 6'($urandom);
            c = 6'($urandom);
         end
         if (n == count / 2 && mode == 1) drain();
         send_word($urandom_range(0, 9) < 3 ? OP_SET : OP_FLIP, r, c,
                   1'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 0;
      set_couplings(16'h0400, 16'hFE00, 16'h0100, 16'h0080, 16'hFF80, 16'h0040);
      send_word(OP_SET, 0, 0, 0, 16'hFFFF);
      send_word(OP_SET, 0, 0, 0, 16'h0000);
      send_word(OP_SET, 63, 63, 1, 16'h1234);
      send_word(OP_SET, 0, 63, 0, 0);
      send_word(OP_SET, 63, 0, 0, 0);
      send_word(OP_SET, 1, 1, 0, 0);
      send_word(OP_SET, 2, 2, 0, 0);
      send_word(OP_FLIP, 0, 0, 1, 16'h0000);
      send_word(OP_FLIP, 0, 0, 0, 16'hFFFF);
      send_word(OP_FLIP, 63, 63, 0, 16'hFFFF);
      send_word(OP_FLIP, 62, 1, 1, 16'h8000);
      send_word(OP_SET, 0, 0, 1, 0);
      send_word(OP_SET, 1, 1, 1, 0);
      set_couplings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(OP_FLIP, 5, 5, 0, 16'hFFFF);
      send_word(OP_FLIP, 0, 63, 0, 16'h0000);
      send_word(OP_FLIP, 63, 0, 1, 16'hFFFF);
      set_couplings(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_word(OP_FLIP, 5, 5, 0, 16'hFFFF);
      send_word(OP_FLIP, 0, 63, 1, 16'hFFFF);
      send_word(OP_FLIP, 33, 17, 0, 16'h0001);
      no_gaps = 1;
      random_run(150, 0);
      no_gaps = 0;
      set_couplings(rand_coef(0), rand_coef(0), rand_coef(0), rand_coef(0),
                    rand_coef(0), rand_coef(0));
      random_run(300, 1);
      set_couplings(rand_coef(1), rand_coef(1), rand_coef(1), rand_coef(1),
                    rand_coef(1), rand_coef(1));
      random_run(250, 0);
      set_couplings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_run(200, 0);
      set_couplings(rand_coef(0), rand_coef(0), rand_coef(0), rand_coef(0),
                    rand_coef(0), rand_coef(0));
      random_run(300, 1);
      set_couplings(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      random_run(150, 0);
      set_couplings(rand_coef(0), rand_coef(0), rand_coef(0), rand_coef(0),
                    rand_coef(0), rand_coef(0));
      random_run(150, 0);
      drain();
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+sv
sv/ihb_pkg.sv
sv/ihb_front.sv
sv/ihb_queue.sv
sv/ihb_back.sv
sv/ising_heat_bath_site_update.sv
tb/ihb_lattice_checker.sv
tb/tb_ising_heat_bath_site_update.sv
